/* hw/rtl/sscsw_pkg.sv */
// Shared types, codes and constants of the calibration sweep unit.
package sscsw_pkg;

    // Capture memory geometry.
    localparam int CAPTURE_DEPTH = 256;
    localparam int CAP_AW = $clog2(CAPTURE_DEPTH);
    localparam int CNT_W = $clog2(CAPTURE_DEPTH + 1);

    // Configuration register index width and codes.
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INIT_VALVE  = 3'd0,
        REG_INIT_BLOWER = 3'd1,
        REG_VALVE_STEP  = 3'd2,
        REG_BLOWER_STEP = 3'd3,
        REG_BLOWER_LIM  = 3'd4,
        REG_FINISH_SPD  = 3'd5,
        REG_DWELL_TICKS = 3'd6
    } cfg_index_t;

    // Register reset values.
    localparam logic [15:0] INIT_VALVE_RST  = 16'd2500;
    localparam logic [15:0] INIT_BLOWER_RST = 16'd35000;
    localparam logic [15:0] VALVE_STEP_RST  = 16'd100;
    localparam logic [15:0] BLOWER_STEP_RST = 16'd500;
    localparam logic [15:0] BLOWER_LIM_RST  = 16'd35000;
    localparam logic [15:0] FINISH_SPD_RST  = 16'd5000;
    localparam logic [15:0] DWELL_TICKS_RST = 16'd10000;

    // Input action codes.
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_RESET = 2'd1,
        ACT_START = 2'd2,
        ACT_READ  = 2'd3
    } action_t;

    // One capture memory entry.
    typedef struct packed {
        logic [15:0] low_word;
        logic [15:0] high_word;
        logic [31:0] flow;
    } capture_entry_t;

endpackage

/* hw/rtl/stepped_setpoint_calibration_sweep_unit.sv */
// Top level of the stepped setpoint calibration sweep unit.
//
//  Channel | Handshake                 | Payload
//  --------+---------------------------+------------------------------------------
//  in      | in_valid / in_ready       | action, sensor words, flow, read_index
//  out     | out_valid / out_ready     | setpoints, status flags, count, read entry
//  cfg     | cfg_we (no back-pressure) | cfg_index, cfg_wdata
//
// One item is taken per cycle unless the output stalls; each result goes through
// the update stage (for the registered memory read) and then the output register.
// Scalar state updates in the transfer cycle, so items follow back to back.
// A stalled output holds one result plus one in flight before in_ready drops.
// rst_n clears all control state and loads the register defaults at once;
// the capture memory needs no clearing since reads are gated by the count.
module stepped_setpoint_calibration_sweep_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration port.
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [15:0]           cfg_wdata,
    // Input channel.
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            action,
    input  logic [15:0]           sensor_low_word,
    input  logic [15:0]           sensor_high_word,
    input  logic signed [31:0]    measured_flow,
    input  logic [7:0]            read_index,
    // Output channel.
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [15:0]           valve_command,
    output logic [16:0]           blower_command,
    output logic                  sweeping,
    output logic                  captured,
    output logic                  capture_full,
    output logic [8:0]            capture_count,
    output logic [15:0]           read_low_word,
    output logic [15:0]           read_high_word,
    output logic signed [31:0]    read_flow
);

    localparam int CNT_W = sscsw_pkg::CNT_W;
    localparam int CAP_AW = sscsw_pkg::CAP_AW;

    // Status carried from the update stage to the output stage.
    typedef struct packed {
        logic [15:0]      valve;
        logic [16:0]      blower;
        logic             sweeping;
        logic             captured;
        logic             full;
        logic [CNT_W-1:0] count;
        logic             read_hit;
    } stage_status_t;

    // Configuration registers.
    logic [15:0] init_valve_reg, init_blower_reg, valve_step_reg, blower_step_reg;
    logic [15:0] blower_lim_reg, finish_spd_reg, dwell_ticks_reg;

    // Sweep state.
    logic             sweep_mode_reg, sweep_mode_next;
    logic [15:0]      valve_reg, valve_next;
    logic [16:0]      speed_reg, speed_next;
    logic [16:0]      blower_out_reg, blower_out_next;
    logic [15:0]      dwell_reg, dwell_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Pipeline registers.
    logic          s1_valid_reg;
    stage_status_t s1_reg, s1_next;
    logic          out_valid_reg;
    stage_status_t out_reg;
    logic [15:0]   out_low_reg, out_high_reg;
    logic [31:0]   out_flow_reg;

    logic in_fire, s1_adv;
    logic [15:0] dwell_inc;
    logic        dwell_done, wr_en, mem_has_room;
    sscsw_pkg::capture_entry_t wr_data, rd_data;
    sscsw_pkg::action_t act;

    assign act = sscsw_pkg::action_t'(action);

    // Handshake: the update stage moves on when the output register is free.
    assign s1_adv   = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_fire  = in_valid && in_ready;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_valve_reg  <= sscsw_pkg::INIT_VALVE_RST;
            init_blower_reg <= sscsw_pkg::INIT_BLOWER_RST;
            valve_step_reg  <= sscsw_pkg::VALVE_STEP_RST;
            blower_step_reg <= sscsw_pkg::BLOWER_STEP_RST;
            blower_lim_reg  <= sscsw_pkg::BLOWER_LIM_RST;
            finish_spd_reg  <= sscsw_pkg::FINISH_SPD_RST;
            dwell_ticks_reg <= sscsw_pkg::DWELL_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (sscsw_pkg::cfg_index_t'(cfg_index))
                sscsw_pkg::REG_INIT_VALVE:  init_valve_reg  <= cfg_wdata;
                sscsw_pkg::REG_INIT_BLOWER: init_blower_reg <= cfg_wdata;
                sscsw_pkg::REG_VALVE_STEP:  valve_step_reg  <= cfg_wdata;
                sscsw_pkg::REG_BLOWER_STEP: blower_step_reg <= cfg_wdata;
                sscsw_pkg::REG_BLOWER_LIM:  blower_lim_reg  <= cfg_wdata;
                sscsw_pkg::REG_FINISH_SPD:  finish_spd_reg  <= cfg_wdata;
                sscsw_pkg::REG_DWELL_TICKS: dwell_ticks_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Dwell timer increment, saturating at full scale.
    assign dwell_inc    = (dwell_reg != 16'hFFFF) ? dwell_reg + 16'd1 : dwell_reg;
    assign dwell_done   = (dwell_inc >= dwell_ticks_reg);
    assign mem_has_room = (32'(count_reg) < 32'(sscsw_pkg::CAPTURE_DEPTH));

    // Next state of the sweep for the item in transfer.
    always_comb
    begin
        sweep_mode_next = sweep_mode_reg;
        valve_next      = valve_reg;
        speed_next      = speed_reg;
        blower_out_next = blower_out_reg;
        dwell_next      = dwell_reg;
        count_next      = count_reg;
        wr_en           = 1'b0;
        s1_next.captured = 1'b0;
        s1_next.full     = 1'b0;
        s1_next.read_hit = 1'b0;
        case (act)
            sscsw_pkg::ACT_TICK:
            begin
                if (sweep_mode_reg)
                begin
                    dwell_next = dwell_inc;
                    if (dwell_done)
                    begin
                        dwell_next = 16'd0;
                        if (mem_has_room)
                        begin
                            wr_en            = 1'b1;
                            count_next       = count_reg + CNT_W'(1);
                            s1_next.captured = 1'b1;
                        end
                        else
                        begin
                            s1_next.full = 1'b1;
                        end
                        // Step the valve down, then the blower up, then finish.
                        if (valve_reg >= valve_step_reg)
                        begin
                            valve_next = valve_reg - valve_step_reg;
                        end
                        else if (speed_reg <= {1'b0, blower_lim_reg})
                        begin
                            speed_next      = speed_reg + {1'b0, blower_step_reg};
                            blower_out_next = speed_reg + {1'b0, blower_step_reg};
                        end
                        else
                        begin
                            blower_out_next = {1'b0, finish_spd_reg};
                            sweep_mode_next = 1'b0;
                        end
                    end
                end
            end
            sscsw_pkg::ACT_RESET:
            begin
                valve_next      = init_valve_reg;
                speed_next      = {1'b0, init_blower_reg};
                count_next      = '0;
                dwell_next      = 16'd0;
                sweep_mode_next = 1'b0;
            end
            sscsw_pkg::ACT_START:
            begin
                blower_out_next = speed_reg;
                dwell_next      = 16'd0;
                sweep_mode_next = 1'b1;
            end
            sscsw_pkg::ACT_READ:
            begin
                s1_next.read_hit = (32'(read_index) < 32'(count_reg)) &&
                                   (32'(read_index) < 32'(sscsw_pkg::CAPTURE_DEPTH));
            end
            default: ;
        endcase
        s1_next.valve    = valve_next;
        s1_next.blower   = blower_out_next;
        s1_next.sweeping = sweep_mode_next;
        s1_next.count    = count_next;
    end

    // Sweep state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_mode_reg <= 1'b0;
            valve_reg      <= sscsw_pkg::INIT_VALVE_RST;
            speed_reg      <= {1'b0, sscsw_pkg::INIT_BLOWER_RST};
            blower_out_reg <= '0;
            dwell_reg      <= '0;
            count_reg      <= '0;
        end
        else if (in_fire)
        begin
            sweep_mode_reg <= sweep_mode_next;
            valve_reg      <= valve_next;
            speed_reg      <= speed_next;
            blower_out_reg <= blower_out_next;
            dwell_reg      <= dwell_next;
            count_reg      <= count_next;
        end
    end

    // Capture memory. A write and a read never come from the same item, and a
    // read issued after a write sees it, so no forwarding is needed.
    assign wr_data.low_word  = sensor_low_word;
    assign wr_data.high_word = sensor_high_word;
    assign wr_data.flow      = measured_flow;

    sscsw_capture_mem u_capture_mem (
        .clk     (clk),
        .wr_en   (in_fire && wr_en),
        .wr_addr (count_reg[CAP_AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (in_fire && (act == sscsw_pkg::ACT_READ)),
        .rd_addr (CAP_AW'(read_index)),
        .rd_data (rd_data)
    );

    // Update stage: waits for the memory read to return.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_reg <= s1_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            out_reg      <= s1_reg;
            out_low_reg  <= s1_reg.read_hit ? rd_data.low_word  : 16'd0;
            out_high_reg <= s1_reg.read_hit ? rd_data.high_word : 16'd0;
            out_flow_reg <= s1_reg.read_hit ? rd_data.flow      : 32'd0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign valve_command  = out_reg.valve;
    assign blower_command = out_reg.blower;
    assign sweeping       = out_reg.sweeping;
    assign captured       = out_reg.captured;
    assign capture_full   = out_reg.full;
    assign capture_count  = 9'(out_reg.count);
    assign read_low_word  = out_low_reg;
    assign read_high_word = out_high_reg;
    assign read_flow      = out_flow_reg;

endmodule

/* hw/rtl/sscsw_capture_mem.sv */
// Capture memory: one write port and one registered read port.
module sscsw_capture_mem (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [sscsw_pkg::CAP_AW-1:0]     wr_addr,
    input  sscsw_pkg::capture_entry_t        wr_data,
    input  logic                             rd_en,
    input  logic [sscsw_pkg::CAP_AW-1:0]     rd_addr,
    output sscsw_pkg::capture_entry_t        rd_data
);

    sscsw_pkg::capture_entry_t mem [sscsw_pkg::CAPTURE_DEPTH];
    sscsw_pkg::capture_entry_t rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/sscsw_checker.sv */
// Port-level checker for the calibration sweep unit, with its bind statement.
module sscsw_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic [15:0]         valve_command,
    input logic [16:0]         blower_command,
    input logic                captured,
    input logic                capture_full,
    input logic [8:0]          capture_count
);

    // A stalled result holds its setpoints and count.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(valve_command) &&
        $stable(blower_command) && $stable(capture_count))
        else $error("stalled result changed");

    // A tick either stores or drops a capture, never both.
    a_cap_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(captured && capture_full))
        else $error("captured and capture_full both set");

    // A stored capture leaves at least one entry counted.
    a_cap_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && captured |-> capture_count != 9'd0)
        else $error("capture reported with zero count");

    // A dropped capture only happens with the memory full.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && capture_full |->
        capture_count == 9'(sscsw_pkg::CAPTURE_DEPTH))
        else $error("capture dropped before memory full");

endmodule

bind stepped_setpoint_calibration_sweep_unit sscsw_checker u_sscsw_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .valve_command  (valve_command),
    .blower_command (blower_command),
    .captured       (captured),
    .capture_full   (capture_full),
    .capture_count  (capture_count)
);

/* verif/tb_stepped_setpoint_calibration_sweep_unit.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the stepped setpoint calibration sweep unit.
module tb_stepped_setpoint_calibration_sweep_unit;

    localparam int CYCLE_LIMIT = 300000;
    localparam int NUM_REGS = 7;

    // One result as the block should present it.
    typedef struct {
        logic [15:0] valve_command;
        logic [16:0] blower_command;
        logic        sweeping;
        logic        captured;
        logic        capture_full;
        logic [8:0]  capture_count;
        logic [15:0] read_low_word;
        logic [15:0] read_high_word;
        logic [31:0] read_flow;
    } sweep_result_t;

    // Clock, reset and block inputs, all known from time zero.
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic [1:0] action = '0;
    logic [15:0] sensor_low_word = '0;
    logic [15:0] sensor_high_word = '0;
    logic signed [31:0] measured_flow = '0;
    logic [7:0] read_index = '0;
    logic out_ready = 1'b0;

    // Block outputs.
    logic in_ready;
    logic out_valid;
    logic [15:0] valve_command;
    logic [16:0] blower_command;
    logic sweeping;
    logic captured;
    logic capture_full;
    logic [8:0] capture_count;
    logic [15:0] read_low_word;
    logic [15:0] read_high_word;
    logic signed [31:0] read_flow;

    // Predicted sweep state and register copies.
    logic [15:0] reg_val [NUM_REGS];
    logic [15:0] next_regs [NUM_REGS];
    logic        sweep_on;
    logic [15:0] valve_set;
    logic [16:0] blower_spd;
    logic [16:0] blower_out;
    logic [15:0] dwell_cnt;
    logic [8:0]  cap_count;
    logic [15:0] cap_low [sscsw_pkg::CAPTURE_DEPTH];
    logic [15:0] cap_high [sscsw_pkg::CAPTURE_DEPTH];
    logic [31:0] cap_flow [sscsw_pkg::CAPTURE_DEPTH];

    sweep_result_t pending_results [$];
    int errors = 0;
    int cycles = 0;
    bit no_idle = 1'b0;

    stepped_setpoint_calibration_sweep_unit i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .action           (action),
        .sensor_low_word  (sensor_low_word),
        .sensor_high_word (sensor_high_word),
        .measured_flow    (measured_flow),
        .read_index       (read_index),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .valve_command    (valve_command),
        .blower_command   (blower_command),
        .sweeping         (sweeping),
        .captured         (captured),
        .capture_full     (capture_full),
        .capture_count    (capture_count),
        .read_low_word    (read_low_word),
        .read_high_word   (read_high_word),
        .read_flow        (read_flow)
    );

    always #5 clk = ~clk;

    // Random idle decision shared by both channels.
    function automatic bit idle_now();
        return !no_idle && ($urandom_range(0, 99) < 27);
    endfunction

    // Computes the result of one transfer and advances the predicted state.
    function automatic sweep_result_t predict_sweep_result(input sscsw_pkg::action_t act,
                                                           input logic [15:0] lo,
                                                           input logic [15:0] hi,
                                                           input logic [31:0] fl,
                                                           input logic [7:0] ri);
        sweep_result_t r;
        r.captured = 1'b0;
        r.capture_full = 1'b0;
        r.read_low_word = '0;
        r.read_high_word = '0;
        r.read_flow = '0;
        case (act)
            sscsw_pkg::ACT_TICK:
            begin
                if (sweep_on)
                begin
                    if (dwell_cnt < 16'hFFFF)
                        dwell_cnt = dwell_cnt + 16'd1;
                    if (dwell_cnt >= reg_val[sscsw_pkg::REG_DWELL_TICKS])
                    begin
                        // Store the sample unless the memory is already full.
                        if (cap_count < sscsw_pkg::CAPTURE_DEPTH)
                        begin
                            cap_low[cap_count] = lo;
                            cap_high[cap_count] = hi;
                            cap_flow[cap_count] = fl;
                            cap_count = cap_count + 9'd1;
                            r.captured = 1'b1;
                        end
                        else
                            r.capture_full = 1'b1;
                        dwell_cnt = '0;
                        // Step the valve first, then the blower, then finish.
                        if (valve_set >= reg_val[sscsw_pkg::REG_VALVE_STEP])
                            valve_set = valve_set - reg_val[sscsw_pkg::REG_VALVE_STEP];
                        else if (blower_spd <= {1'b0, reg_val[sscsw_pkg::REG_BLOWER_LIM]})
                        begin
                            blower_spd = blower_spd +
                                         {1'b0, reg_val[sscsw_pkg::REG_BLOWER_STEP]};
                            blower_out = blower_spd;
                        end
                        else
                        begin
                            blower_out = {1'b0, reg_val[sscsw_pkg::REG_FINISH_SPD]};
                            sweep_on = 1'b0;
                        end
                    end
                end
            end
            sscsw_pkg::ACT_RESET:
            begin
                valve_set = reg_val[sscsw_pkg::REG_INIT_VALVE];
                blower_spd = {1'b0, reg_val[sscsw_pkg::REG_INIT_BLOWER]};
                cap_count = '0;
                dwell_cnt = '0;
                sweep_on = 1'b0;
            end
            sscsw_pkg::ACT_START:
            begin
                blower_out = blower_spd;
                dwell_cnt = '0;
                sweep_on = 1'b1;
            end
            default:
            begin
                if (ri < cap_count)
                begin
                    r.read_low_word = cap_low[ri];
                    r.read_high_word = cap_high[ri];
                    r.read_flow = cap_flow[ri];
                end
            end
        endcase
        r.valve_command = valve_set;
        r.blower_command = blower_out;
        r.sweeping = sweep_on;
        r.capture_count = cap_count;
        return r;
    endfunction

    // Sends one item and records its expected result on transfer.
    task automatic send_item(input sscsw_pkg::action_t act, input logic [15:0] lo,
                             input logic [15:0] hi, input logic [31:0] fl,
                             input logic [7:0] ri);
        while (idle_now())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        sensor_low_word <= lo;
        sensor_high_word <= hi;
        measured_flow <= fl;
        read_index <= ri;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(predict_sweep_result(act, lo, hi, fl, ri));
    endtask

    // Sends one item of the given action with random content.
    task automatic send_random(input sscsw_pkg::action_t act);
        logic [7:0] ri;
        if (cap_count != 0 && $urandom_range(0, 1) == 1)
            ri = 8'($urandom_range(32'(cap_count) - 1, 0));
        else
            ri = 8'($urandom_range(255, 0));
        send_item(act, 16'($urandom), 16'($urandom), $urandom, ri);
    endtask

    // Stops sending and waits until every expected result has come.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Writes all registers from next_regs while the block is idle.
    task automatic load_registers();
        wait_for_results();
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= sscsw_pkg::cfg_index_t'(i);
            cfg_wdata <= next_regs[i];
            @(posedge clk);
            reg_val[i] = next_regs[i];
        end
        cfg_we <= 1'b0;
    endtask

    // Register value biased toward the ends of its range.
    function automatic logic [15:0] pick_reg_value(input logic [15:0] lo);
        logic [15:0] v;
        case ($urandom_range(0, 5))
            0: v = lo;
            1: v = 16'hFFFF;
            2, 3: v = 16'($urandom_range(65535, 32'(lo)));
            default: v = 16'($urandom_range(600, 32'(lo)));
        endcase
        return v;
    endfunction

    task automatic report_field(input string name, input logic [31:0] expv,
                                input logic [31:0] actv);
        if (expv !== actv)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expv, actv);
            errors++;
        end
    endtask

    // Default registers: a read, a tick while stopped, a start and a long dwell.
    task automatic test_power_on();
        send_item(sscsw_pkg::ACT_READ, 16'h0000, 16'h0000, 32'h0, 8'h00);
        send_item(sscsw_pkg::ACT_TICK, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 8'hFF);
        send_item(sscsw_pkg::ACT_START, 16'h1234, 16'h5678, 32'h0, 8'h00);
        send_item(sscsw_pkg::ACT_TICK, 16'h0001, 16'h0002, 32'h3, 8'h00);
        send_item(sscsw_pkg::ACT_RESET, 16'h0, 16'h0, 32'h0, 8'h00);
    endtask

    // Valve steps, a blower step to the widest speed, finish and read-back.
    task automatic test_sweep_extremes();
        next_regs[sscsw_pkg::REG_INIT_VALVE] = 16'd250;
        next_regs[sscsw_pkg::REG_INIT_BLOWER] = 16'd1000;
        next_regs[sscsw_pkg::REG_VALVE_STEP] = 16'd100;
        next_regs[sscsw_pkg::REG_BLOWER_STEP] = 16'hFFFF;
        next_regs[sscsw_pkg::REG_BLOWER_LIM] = 16'hFFFF;
        next_regs[sscsw_pkg::REG_FINISH_SPD] = 16'h0000;
        next_regs[sscsw_pkg::REG_DWELL_TICKS] = 16'd1;
        load_registers();
        send_item(sscsw_pkg::ACT_RESET, 16'h0, 16'h0, 32'h0, 8'h00);
        send_item(sscsw_pkg::ACT_START, 16'h0, 16'h0, 32'h0, 8'h00);
        send_item(sscsw_pkg::ACT_TICK, 16'h0000, 16'h0000, 32'h80000000, 8'h00);
        send_item(sscsw_pkg::ACT_TICK, 16'hFFFF, 16'hFFFF, 32'h7FFFFFFF, 8'h00);
        send_item(sscsw_pkg::ACT_TICK, 16'hA5A5, 16'h5A5A, 32'hFFFFFFFF, 8'h00);
        send_item(sscsw_pkg::ACT_TICK, 16'h5A5A, 16'hA5A5, 32'h00000000, 8'h00);
        // The sweep has finished, so this tick changes nothing.
        send_item(sscsw_pkg::ACT_TICK, 16'h1111, 16'h2222, 32'h33333333, 8'h00);
        for (int i = 0; i < 5; i++)
            send_item(sscsw_pkg::ACT_READ, 16'h0, 16'h0, 32'h0, i[7:0]);
        send_item(sscsw_pkg::ACT_READ, 16'h0, 16'h0, 32'h0, 8'hFF);
        send_item(sscsw_pkg::ACT_START, 16'h0, 16'h0, 32'h0, 8'h00);
        send_item(sscsw_pkg::ACT_RESET, 16'h0, 16'h0, 32'h0, 8'h00);
    endtask

    // A start while sweeping restarts the dwell; exhausted valve finishes at once.
    task automatic test_dwell_restart();
        next_regs[sscsw_pkg::REG_INIT_VALVE] = 16'h0000;
        next_regs[sscsw_pkg::REG_INIT_BLOWER] = 16'hFFFF;
        next_regs[sscsw_pkg::REG_VALVE_STEP] = 16'hFFFF;
        next_regs[sscsw_pkg::REG_BLOWER_STEP] = 16'h0000;
        next_regs[sscsw_pkg::REG_BLOWER_LIM] = 16'h0000;
        next_regs[sscsw_pkg::REG_FINISH_SPD] = 16'hFFFF;
        next_regs[sscsw_pkg::REG_DWELL_TICKS] = 16'd3;
        load_registers();
        send_item(sscsw_pkg::ACT_RESET, 16'h0, 16'h0, 32'h0, 8'h00);
        send_item(sscsw_pkg::ACT_START, 16'h0, 16'h0, 32'h0, 8'h00);
        send_random(sscsw_pkg::ACT_TICK);
        send_random(sscsw_pkg::ACT_TICK);
        send_item(sscsw_pkg::ACT_START, 16'h0, 16'h0, 32'h0, 8'h00);
        send_random(sscsw_pkg::ACT_TICK);
        send_random(sscsw_pkg::ACT_TICK);
        send_random(sscsw_pkg::ACT_TICK);
    endtask

    // Fills the capture memory past its depth, then reads it back.
    task automatic test_capture_overflow();
        next_regs[sscsw_pkg::REG_INIT_VALVE] = 16'hFFFF;
        next_regs[sscsw_pkg::REG_INIT_BLOWER] = 16'h0000;
        next_regs[sscsw_pkg::REG_VALVE_STEP] = 16'd1;
        next_regs[sscsw_pkg::REG_BLOWER_STEP] = 16'd1;
        next_regs[sscsw_pkg::REG_BLOWER_LIM] = 16'd100;
        next_regs[sscsw_pkg::REG_FINISH_SPD] = 16'($urandom_range(65535, 0));
        next_regs[sscsw_pkg::REG_DWELL_TICKS] = 16'd1;
        load_registers();
        send_item(sscsw_pkg::ACT_RESET, 16'h0, 16'h0, 32'h0, 8'h00);
        send_item(sscsw_pkg::ACT_START, 16'h0, 16'h0, 32'h0, 8'h00);
        repeat (sscsw_pkg::CAPTURE_DEPTH + 6)
            send_random(sscsw_pkg::ACT_TICK);
        repeat (48)
            send_random(sscsw_pkg::ACT_READ);
        send_item(sscsw_pkg::ACT_READ, 16'h0, 16'h0, 32'h0, 8'hFF);
    endtask

    // Random register settings, each followed by a mostly well-formed sweep.
    task automatic test_random_sweeps();
        int r;
        for (int phase = 0; phase < 10; phase++)
        begin
            next_regs[sscsw_pkg::REG_INIT_VALVE] = pick_reg_value(16'd0);
            next_regs[sscsw_pkg::REG_INIT_BLOWER] = pick_reg_value(16'd0);
            next_regs[sscsw_pkg::REG_VALVE_STEP] = pick_reg_value(16'd1);
            next_regs[sscsw_pkg::REG_BLOWER_STEP] = pick_reg_value(16'd0);
            next_regs[sscsw_pkg::REG_BLOWER_LIM] = pick_reg_value(16'd0);
            next_regs[sscsw_pkg::REG_FINISH_SPD] = pick_reg_value(16'd0);
            if (phase == 3)
                next_regs[sscsw_pkg::REG_DWELL_TICKS] = 16'hFFFF;
            else if ($urandom_range(0, 3) == 0)
                next_regs[sscsw_pkg::REG_DWELL_TICKS] = 16'($urandom_range(12, 1));
            else
                next_regs[sscsw_pkg::REG_DWELL_TICKS] = 16'($urandom_range(4, 1));
            load_registers();
            no_idle = (phase == 6);
            send_random(sscsw_pkg::ACT_RESET);
            send_random(sscsw_pkg::ACT_START);
            for (int n = 0; n < 55; n++)
            begin
                r = $urandom_range(99, 0);
                if (r < 72)
                    send_random(sscsw_pkg::ACT_TICK);
                else if (r < 86)
                    send_random(sscsw_pkg::ACT_READ);
                else if (r < 93)
                    send_random(sscsw_pkg::ACT_START);
                else
                begin
                    send_random(sscsw_pkg::ACT_RESET);
                    if ($urandom_range(0, 3) != 0)
                        send_random(sscsw_pkg::ACT_START);
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // Output back-pressure.
    always @(posedge clk)
        out_ready <= !idle_now();

    // Compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        sweep_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result transfer with no expected result", $time);
                errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                report_field("valve_command", 32'(exp_r.valve_command),
                             32'(valve_command));
                report_field("blower_command", 32'(exp_r.blower_command),
                             32'(blower_command));
                report_field("sweeping", 32'(exp_r.sweeping), 32'(sweeping));
                report_field("captured", 32'(exp_r.captured), 32'(captured));
                report_field("capture_full", 32'(exp_r.capture_full), 32'(capture_full));
                report_field("capture_count", 32'(exp_r.capture_count),
                             32'(capture_count));
                report_field("read_low_word", 32'(exp_r.read_low_word),
                             32'(read_low_word));
                report_field("read_high_word", 32'(exp_r.read_high_word),
                             32'(read_high_word));
                report_field("read_flow", exp_r.read_flow, read_flow);
            end
        end
    end

    // Run time limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_stepped_setpoint_calibration_sweep_unit: FAIL");
            $finish;
        end
    end

    initial
    begin
        // Predicted state after reset.
        reg_val[sscsw_pkg::REG_INIT_VALVE] = sscsw_pkg::INIT_VALVE_RST;
        reg_val[sscsw_pkg::REG_INIT_BLOWER] = sscsw_pkg::INIT_BLOWER_RST;
        reg_val[sscsw_pkg::REG_VALVE_STEP] = sscsw_pkg::VALVE_STEP_RST;
        reg_val[sscsw_pkg::REG_BLOWER_STEP] = sscsw_pkg::BLOWER_STEP_RST;
        reg_val[sscsw_pkg::REG_BLOWER_LIM] = sscsw_pkg::BLOWER_LIM_RST;
        reg_val[sscsw_pkg::REG_FINISH_SPD] = sscsw_pkg::FINISH_SPD_RST;
        reg_val[sscsw_pkg::REG_DWELL_TICKS] = sscsw_pkg::DWELL_TICKS_RST;
        sweep_on = 1'b0;
        valve_set = sscsw_pkg::INIT_VALVE_RST;
        blower_spd = {1'b0, sscsw_pkg::INIT_BLOWER_RST};
        blower_out = '0;
        dwell_cnt = '0;
        cap_count = '0;
        for (int i = 0; i < sscsw_pkg::CAPTURE_DEPTH; i++)
        begin
            cap_low[i] = '0;
            cap_high[i] = '0;
            cap_flow[i] = '0;
        end

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_on();
        test_sweep_extremes();
        test_dwell_restart();
        test_capture_overflow();
        test_random_sweeps();

        // Drain, then allow the pipeline to settle.
        wait_for_results();
        repeat (10)
            @(posedge clk);
        if (errors == 0)
            $display("tb_stepped_setpoint_calibration_sweep_unit: PASS");
        else
            $display("tb_stepped_setpoint_calibration_sweep_unit: FAIL");
        $finish;
    end

endmodule
